>>> sv/ilid_pkg.sv
package ilid_pkg;

    // Field widths fixed by the request and result formats
    localparam int OP_W      = 3;
    localparam int POS_W     = 10;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int LEN_OUT_W = 7;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;

    // Taps merged per group in the first level of the read tree
    localparam int GROUP = 32;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 3'd0,
        OP_HEAD   = 3'd1,
        OP_TAIL   = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What every cell does on one edge
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic               rd;
        logic [POS_W-1:0]   pos;
        word_t              data;
    } cell_cmd_t;

endpackage

>>> sv/ilid_cell.sv
module ilid_cell #(
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  ilid_pkg::cell_cmd_t cmd,
    input  ilid_pkg::word_t    left,   // value held by the cell one place lower
    input  ilid_pkg::word_t    right,  // value held by the cell one place higher
    output ilid_pkg::word_t    value,
    output ilid_pkg::word_t    tap
);

    localparam logic [ilid_pkg::POS_W-1:0] MY_POS = ilid_pkg::POS_W'(INDEX);

    ilid_pkg::word_t value_reg, value_next;
    ilid_pkg::word_t tap_reg, tap_next;

    // Shift up on insert, down on delete, load at the insert position
    always_comb
    begin
        value_next = value_reg;
        unique case (cmd.op)
            ilid_pkg::CELL_INSERT:
            begin
                if (MY_POS > cmd.pos)
                    value_next = left;
                else if (MY_POS == cmd.pos)
                    value_next = cmd.data;
            end
            ilid_pkg::CELL_DELETE:
            begin
                if (MY_POS >= cmd.pos)
                    value_next = right;
            end
            default:
                value_next = value_reg;
        endcase
    end

    // Read tap: own value when addressed, zero otherwise
    always_comb
    begin
        tap_next = '0;
        if (cmd.rd && (MY_POS == cmd.pos))
            tap_next = value_reg;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        tap_reg   <= tap_next;
    end

    assign value = value_reg;
    assign tap   = tap_reg;

endmodule

>>> sv/ilid_merge.sv
module ilid_merge #(
    parameter int CAPACITY = 64
) (
    input  logic            clk,
    input  logic            load,
    input  ilid_pkg::word_t taps [CAPACITY],
    output ilid_pkg::word_t merged
);

    localparam int GROUP  = ilid_pkg::GROUP;
    localparam int GROUPS = (CAPACITY + GROUP - 1) / GROUP;

    ilid_pkg::word_t grp_or [GROUPS];
    ilid_pkg::word_t grp_reg [GROUPS];

    // First level: OR of up to GROUP taps per group
    for (genvar g = 0; g < GROUPS; g++)
    begin : g_grp
        ilid_pkg::word_t part [GROUP];

        for (genvar j = 0; j < GROUP; j++)
        begin : g_mem
            if (g * GROUP + j < CAPACITY)
            begin : g_used
                assign part[j] = taps[g * GROUP + j];
            end
            else
            begin : g_pad
                assign part[j] = '0;
            end
        end

        always_comb
        begin
            grp_or[g] = '0;
            for (int j = 0; j < GROUP; j++)
                grp_or[g] = grp_or[g] | part[j];
        end

        always_ff @(posedge clk)
        begin
            if (load)
                grp_reg[g] <= grp_or[g];
        end
    end

    // Second level: OR of the group registers
    always_comb
    begin
        merged = '0;
        for (int g = 0; g < GROUPS; g++)
            merged = merged | grp_reg[g];
    end

endmodule

>>> sv/indexed_list_insert_delete.sv
// Ordered list of up to CAPACITY signed 32-bit values, one request per item
// (read at position, insert at head, append, insert before position, delete
// at position), one result per item with the status and the new length.
// Storage is a row of CAPACITY cells; on insert or delete the cells at and above
// the position load on the same edge, so list updates, reads past the end and
// rejected requests give their result in the cycle after they are taken. A read
// inside the list passes the registered cell taps and a two-level OR tree whose
// first level is registered, then waits for a free result register. A new item is
// taken once the previous one has finished its cells and the result register
// is free or being emptied. The list is empty after reset; no clearing pass is needed.
module indexed_list_insert_delete #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // operation[2:0], position[12:3], value[44:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], status[33:32], length_after[40:34]
);

    localparam int POS_W = ilid_pkg::POS_W;
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int LOW   = ilid_pkg::LEN_OUT_W;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_MERGE
    } state_t;

    state_t state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic out_valid_reg, out_valid_next;
    ilid_pkg::word_t out_value_reg, out_value_next;
    ilid_pkg::status_t out_status_reg, out_status_next;
    logic [LOW-1:0] out_len_reg, out_len_next;

    // Input field unpacking
    logic [ilid_pkg::OP_W-1:0] in_op;
    logic [POS_W-1:0]          in_pos;
    ilid_pkg::word_t           in_value;

    assign in_op    = s_tdata[2:0];
    assign in_pos   = s_tdata[12:3];
    assign in_value = s_tdata[44:13];

    logic accept;
    logic out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Request decode against the current length
    logic [CMP_W-1:0] len_c;
    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] ins_pos;
    logic             is_insert;
    logic             rd_hit;
    ilid_pkg::status_t req_status;
    ilid_pkg::cell_cmd_t cmd;

    assign len_c = CMP_W'(len_reg);
    assign pos_c = CMP_W'(in_pos);

    always_comb
    begin
        ins_pos    = '0;
        is_insert  = 1'b0;
        rd_hit     = 1'b0;
        req_status = ilid_pkg::ST_DONE;
        unique case (in_op)
            ilid_pkg::OP_READ:
                rd_hit = (pos_c < len_c);
            ilid_pkg::OP_HEAD:
            begin
                is_insert = 1'b1;
                ins_pos   = '0;
            end
            ilid_pkg::OP_TAIL:
            begin
                is_insert = 1'b1;
                ins_pos   = len_c;
            end
            ilid_pkg::OP_INSERT:
            begin
                is_insert = 1'b1;
                ins_pos   = pos_c;
            end
            ilid_pkg::OP_DELETE:
            begin
                if (pos_c >= len_c)
                    req_status = ilid_pkg::ST_RANGE;
            end
            default:
                req_status = ilid_pkg::ST_RANGE;
        endcase
        if (is_insert)
        begin
            if (ins_pos > len_c)
                req_status = ilid_pkg::ST_RANGE;
            else if (len_c >= CAP_C)
                req_status = ilid_pkg::ST_FULL;
        end
    end

    // Command broadcast to the cell row
    always_comb
    begin
        cmd.op   = ilid_pkg::CELL_HOLD;
        cmd.rd   = accept && rd_hit;
        cmd.pos  = is_insert ? POS_W'(ins_pos) : in_pos;
        cmd.data = in_value;
        if (accept && (req_status == ilid_pkg::ST_DONE))
        begin
            if (is_insert)
                cmd.op = ilid_pkg::CELL_INSERT;
            else if (in_op == ilid_pkg::OP_DELETE)
                cmd.op = ilid_pkg::CELL_DELETE;
        end
    end

    // Cell row
    ilid_pkg::word_t cell_val [CAPACITY];
    ilid_pkg::word_t cell_tap [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        ilid_pkg::word_t left_in;
        ilid_pkg::word_t right_in;

        if (k == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = cell_val[k - 1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_val[k + 1];
        end

        ilid_cell #(
            .INDEX (k)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .left  (left_in),
            .right (right_in),
            .value (cell_val[k]),
            .tap   (cell_tap[k])
        );
    end

    // Read tree
    ilid_pkg::word_t merged;

    ilid_merge #(
        .CAPACITY (CAPACITY)
    ) u_merge (
        .clk    (clk),
        .load   (state_reg == S_GATHER),
        .taps   (cell_tap),
        .merged (merged)
    );

    // Sequencer, length and result register
    always_comb
    begin
        state_next      = state_reg;
        len_next        = len_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.op == ilid_pkg::CELL_INSERT)
                        len_next = len_reg + LEN_W'(1);
                    else if (cmd.op == ilid_pkg::CELL_DELETE)
                        len_next = len_reg - LEN_W'(1);
                    out_status_next = req_status;
                    out_len_next    = LOW'(len_next);
                    if (rd_hit)
                    begin
                        state_next = S_GATHER;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_value_next = (in_op == ilid_pkg::OP_READ) ? '1 : '0;
                    end
                end
            end
            S_GATHER:
                state_next = S_MERGE;
            S_MERGE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = merged;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            len_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_status_reg <= ilid_pkg::ST_DONE;
            out_len_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
            out_len_reg    <= out_len_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_len_reg, out_status_reg, out_value_reg};

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(len_reg) <= CAP_C)
        else $error("list length above capacity");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("input taken while a read is in flight");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.op == ilid_pkg::CELL_INSERT)) |=>
            (len_reg == $past(len_reg) + LEN_W'(1)))
        else $error("insert did not grow the list");

    a_gather_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATHER) |=> (state_reg == S_MERGE))
        else $error("read tree skipped its merge step");
`endif

endmodule

>>> sim/indexed_list_insert_delete_tb.sv
module indexed_list_insert_delete_tb;

    localparam int CAP         = 64;
    localparam int MAX_WAIT    = 16;
    localparam int OP_CODES    = 1 << ilid_pkg::OP_W;
    localparam int RAND_ITEMS  = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;

    // Highest operation code, always an unknown one
    localparam logic [ilid_pkg::OP_W-1:0] OP_TOP = ilid_pkg::OP_W'(OP_CODES - 1);

    // One request as it goes onto the bus
    typedef struct {
        logic [ilid_pkg::OP_W-1:0]  op;
        logic [ilid_pkg::POS_W-1:0] pos;
        ilid_pkg::word_t            value;
        bit                         drain_first;   // hold it back until the block is empty
    } list_request_t;

    // One expected reply
    typedef struct {
        ilid_pkg::word_t                rd;
        ilid_pkg::status_t              st;
        logic [ilid_pkg::LEN_OUT_W-1:0] len;
    } list_reply_t;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } op_mix_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ilid_pkg::IN_DATA_W-1:0]  s_tdata = '0;     // operation, position, value
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ilid_pkg::OUT_DATA_W-1:0] m_tdata;          // read_value, status, length_after

    list_request_t queued_requests[$];
    list_reply_t   expected_replies[$];
    list_request_t on_bus;

    // Predicted list contents
    ilid_pkg::word_t list_words [CAP];
    int              list_count = 0;

    int  n_accepted = 0;
    int  n_received = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  gen_len = 0;
    int  send_gap = 0;
    int  recv_wait = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;

    indexed_list_insert_delete #(
        .CAPACITY(CAP)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 clk = ~clk;

    // Apply one request to the predicted list and return the reply it gives
    function automatic list_reply_t apply_request(list_request_t r);
        list_reply_t res;
        int          slot;
        int          k;
        res.rd = '0;
        res.st = ilid_pkg::ST_DONE;
        case (r.op)
            ilid_pkg::OP_READ:
                res.rd = (r.pos < list_count) ? list_words[r.pos] : '1;
            ilid_pkg::OP_HEAD, ilid_pkg::OP_TAIL, ilid_pkg::OP_INSERT:
            begin
                if (r.op == ilid_pkg::OP_HEAD)
                    slot = 0;
                else if (r.op == ilid_pkg::OP_TAIL)
                    slot = list_count;
                else
                    slot = r.pos;
                // range check wins over the full check
                if (slot > list_count)
                    res.st = ilid_pkg::ST_RANGE;
                else if (list_count >= CAP)
                    res.st = ilid_pkg::ST_FULL;
                else
                begin
                    for (k = list_count; k > slot; k--)
                        list_words[k] = list_words[k-1];
                    list_words[slot] = r.value;
                    list_count++;
                end
            end
            ilid_pkg::OP_DELETE:
            begin
                if (r.pos >= list_count)
                    res.st = ilid_pkg::ST_RANGE;
                else
                begin
                    for (k = r.pos; k + 1 < list_count; k++)
                        list_words[k] = list_words[k+1];
                    list_count--;
                end
            end
            default:
                res.st = ilid_pkg::ST_RANGE;
        endcase
        res.len = ilid_pkg::LEN_OUT_W'(list_count);
        return res;
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Queue a request and track the length it leaves, for position picking
    task automatic add_request(logic [ilid_pkg::OP_W-1:0] op, int pos,
                               ilid_pkg::word_t value, bit drain_first);
        list_request_t r;
        r.op          = op;
        r.pos         = ilid_pkg::POS_W'(pos);
        r.value       = value;
        r.drain_first = drain_first;
        queued_requests.push_back(r);
        case (op)
            ilid_pkg::OP_HEAD, ilid_pkg::OP_TAIL:
                if (gen_len < CAP)
                    gen_len++;
            ilid_pkg::OP_INSERT:
                if (r.pos <= gen_len && gen_len < CAP)
                    gen_len++;
            ilid_pkg::OP_DELETE:
                if (r.pos < gen_len)
                    gen_len--;
            default:
                ;
        endcase
    endtask

    // Random request drawn from the current op mix
    task automatic add_random_request(op_mix_t mix, bit drain_first);
        int                        pick;
        int                        pos;
        logic [ilid_pkg::OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
                op = (pick < 15) ? ilid_pkg::OP_READ : (pick < 35) ? ilid_pkg::OP_HEAD :
                     (pick < 55) ? ilid_pkg::OP_TAIL : (pick < 85) ? ilid_pkg::OP_INSERT :
                     (pick < 97) ? ilid_pkg::OP_DELETE : OP_TOP;
            MIX_SHRINK:
                op = (pick < 20) ? ilid_pkg::OP_READ : (pick < 25) ? ilid_pkg::OP_HEAD :
                     (pick < 30) ? ilid_pkg::OP_TAIL : (pick < 35) ? ilid_pkg::OP_INSERT :
                     (pick < 97) ? ilid_pkg::OP_DELETE : OP_TOP;
            default:
                op = (pick < 30) ? ilid_pkg::OP_READ : (pick < 45) ? ilid_pkg::OP_HEAD :
                     (pick < 60) ? ilid_pkg::OP_TAIL : (pick < 75) ? ilid_pkg::OP_INSERT :
                     (pick < 97) ? ilid_pkg::OP_DELETE : OP_TOP;
        endcase
        if (op == OP_TOP)
            op = ilid_pkg::OP_W'($urandom_range(int'(ilid_pkg::OP_DELETE) + 1, OP_CODES - 1));

        // mostly valid positions, some at the edges, a few anywhere
        pick = $urandom_range(0, 99);
        if (pick < 10)
            pos = $urandom_range(0, (1 << ilid_pkg::POS_W) - 1);
        else if (pick < 22)
            pos = gen_len + $urandom_range(0, 1);
        else if (op == ilid_pkg::OP_INSERT)
            pos = $urandom_range(0, gen_len);
        else
            pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
        add_request(op, pos, $urandom, drain_first);
    endtask

    // Request driver
    always @(posedge clk)
    begin
        logic accepted;
        logic valid_next;
        accepted   = s_tvalid && s_tready;
        valid_next = s_tvalid && !accepted;
        if (accepted)
        begin
            expected_replies.push_back(apply_request(on_bus));
            n_accepted <= n_accepted + 1;
        end
        if (rst_n && !valid_next)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (queued_requests.size() != 0 &&
                     !(queued_requests[0].drain_first &&
                       n_accepted + int'(accepted) != n_received))
            begin
                on_bus = queued_requests.pop_front();
                s_tdata <= {3'b000, on_bus.value, on_bus.pos, on_bus.op};
                valid_next = 1'b1;
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
                send_gap = draw_wait(send_burst);
            end
        end
        s_tvalid <= valid_next;
    end

    // Reply monitor and back-pressure
    always @(posedge clk)
    begin
        ilid_pkg::word_t                got_rd;
        logic [ilid_pkg::STATUS_W-1:0]  got_st;
        logic [ilid_pkg::LEN_OUT_W-1:0] got_len;
        list_reply_t                    want;
        logic                           ready_next;
        ready_next = m_tready;
        if (m_tvalid && m_tready)
        begin
            got_rd  = m_tdata[31:0];
            got_st  = m_tdata[33:32];
            got_len = m_tdata[40:34];
            if (expected_replies.size() == 0)
            begin
                $error("reply with none expected: read_value %0d status %0d length_after %0d",
                       $signed(got_rd), got_st, got_len);
                fail_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got_rd !== want.rd)
                begin
                    $error("read_value: expected %0d, got %0d", $signed(want.rd),
                           $signed(got_rd));
                    fail_count++;
                end
                if (got_st !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, got_st);
                    fail_count++;
                end
                if (got_len !== want.len)
                begin
                    $error("length_after: expected %0d, got %0d", want.len, got_len);
                    fail_count++;
                end
            end
            n_received <= n_received + 1;
            if ($urandom_range(0, 63) == 0)
                recv_burst = !recv_burst;
            recv_wait  = draw_wait(recv_burst);
            ready_next = (recv_wait == 0);
        end
        else if (rst_n && !m_tready)
        begin
            if (recv_wait > 0)
                recv_wait--;
            else
                ready_next = 1'b1;
        end
        m_tready <= ready_next;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("indexed_list_insert_delete_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        op_mix_t mix;
        int      phase_left;
        int      i;

        // Directed: empty list cases, unknown ops
        add_request(ilid_pkg::OP_READ, 0, 32'h0000_1234, 1'b0);
        add_request(ilid_pkg::OP_DELETE, 0, '0, 1'b0);
        add_request(ilid_pkg::OP_INSERT, 1, 32'h5555_5555, 1'b0);
        add_request(ilid_pkg::OP_W'(int'(ilid_pkg::OP_DELETE) + 1), 0, '1, 1'b0);
        add_request(ilid_pkg::OP_W'(int'(ilid_pkg::OP_DELETE) + 2), 7, 32'h0F0F_0F0F, 1'b0);
        add_request(OP_TOP, (1 << ilid_pkg::POS_W) - 1, '1, 1'b0);
        // build a short list with extreme values; insert at length appends
        add_request(ilid_pkg::OP_HEAD, 0, 32'h8000_0000, 1'b0);
        add_request(ilid_pkg::OP_TAIL, 0, 32'h7FFF_FFFF, 1'b0);
        add_request(ilid_pkg::OP_INSERT, 2, 32'hFFFF_FFFF, 1'b0);
        add_request(ilid_pkg::OP_INSERT, 1, 32'h0000_0000, 1'b0);
        add_request(ilid_pkg::OP_INSERT, 0, 32'h0000_0001, 1'b0);
        // reads inside and past the end
        add_request(ilid_pkg::OP_READ, 0, '1, 1'b1);
        add_request(ilid_pkg::OP_READ, 1, '0, 1'b0);
        add_request(ilid_pkg::OP_READ, 2, '0, 1'b0);
        add_request(ilid_pkg::OP_READ, 3, '0, 1'b0);
        add_request(ilid_pkg::OP_READ, 4, '0, 1'b0);
        add_request(ilid_pkg::OP_READ, 5, '0, 1'b0);
        add_request(ilid_pkg::OP_READ, (1 << ilid_pkg::POS_W) - 1, '0, 1'b0);
        // out of range insert and delete
        add_request(ilid_pkg::OP_INSERT, (1 << ilid_pkg::POS_W) - 1, 32'hDEAD_BEEF, 1'b0);
        add_request(ilid_pkg::OP_DELETE, (1 << ilid_pkg::POS_W) - 1, '0, 1'b0);
        // delete tail, head, middle
        add_request(ilid_pkg::OP_DELETE, 4, '0, 1'b0);
        add_request(ilid_pkg::OP_DELETE, 0, '0, 1'b0);
        add_request(ilid_pkg::OP_DELETE, 1, '0, 1'b0);

        // Random: phases that fill to full, drain to empty, or wander
        mix = MIX_GROW;
        phase_left = 0;
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (phase_left == 0)
            begin
                mix = op_mix_t'($urandom_range(0, 2));
                phase_left = $urandom_range(60, 150);
            end
            phase_left--;
            add_random_request(mix, (i % 250) == 249);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (queued_requests.size() != 0 || s_tvalid || n_received != n_accepted)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (expected_replies.size() != 0)
        begin
            $error("%0d replies never arrived", expected_replies.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("indexed_list_insert_delete_tb: PASS");
        else
            $display("indexed_list_insert_delete_tb: FAIL");
        $finish;
    end

endmodule
